// ===== rtl/montgomery_field_alu_256_defines.svh =====
// Assertion macros used by the field ALU final stage module (mfa_final).
`ifndef MONTGOMERY_FIELD_ALU_256_DEFINES_SVH
`define MONTGOMERY_FIELD_ALU_256_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mfa_pkg.sv =====
// Shared types and step codes for the field ALU.
package mfa_pkg;

    localparam int LIMB_W    = 64;
    localparam int LIMBS     = 4;
    localparam int STEPS_RND = 9;
    localparam int N_CELLS   = LIMBS * STEPS_RND;

    typedef enum logic [1:0] {
        KIND_MUL = 2'd0,
        KIND_ADD = 2'd1,
        KIND_SUB = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STEP_AB = 2'd0,
        STEP_M  = 2'd1,
        STEP_R0 = 2'd2,
        STEP_RJ = 2'd3
    } step_op_t;

    typedef struct packed {
        step_op_t   op;
        logic [1:0] i;
        logic [1:0] j;
    } mfa_step_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [3:0][63:0]       a;
        logic [3:0][63:0]       b;
        logic [4:0][63:0]       t;
        logic [63:0]            c;
        logic [63:0]            m;
    } mfa_item_t;

endpackage

// ===== rtl/mfa_cell.sv =====
// One CIOS step cell: a multiply-accumulate on the item in flight, split over two stages.
module mfa_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  mfa_pkg::mfa_step_t  step,
    input  logic [3:0][63:0]    modulus,
    input  logic [63:0]         mont_factor,
    input  logic                in_valid,
    output logic                in_ready,
    input  mfa_pkg::mfa_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mfa_pkg::mfa_item_t  out_item
);
    import mfa_pkg::*;

    logic             va_reg;
    mfa_item_t        item_a_reg;
    logic [3:0][63:0] pp_reg;
    logic             vb_reg;
    mfa_item_t        item_b_reg;

    logic             ready_b;
    logic [63:0]      x_op;
    logic [63:0]      y_op;
    logic [3:0][63:0] pp_next;
    logic [63:0]      s_op;
    logic [63:0]      c_op;
    logic [127:0]     acc;
    mfa_item_t        item_next;
    logic [1:0]       jm1;

    assign ready_b   = !vb_reg || out_ready;
    assign in_ready  = !va_reg || ready_b;
    assign out_valid = vb_reg;
    assign out_item  = item_b_reg;
    assign jm1       = step.j - 2'd1;

    // stage A: pick the multiply operands, form four 32x32 partial products
    always_comb
    begin
        x_op = 64'd0;
        y_op = 64'd0;
        case (step.op)
            STEP_AB:
            begin
                x_op = in_item.a[step.i];
                y_op = in_item.b[step.j];
            end
            STEP_M:
            begin
                x_op = in_item.t[0];
                y_op = mont_factor;
            end
            STEP_R0:
            begin
                x_op = in_item.m;
                y_op = modulus[0];
            end
            STEP_RJ:
            begin
                x_op = in_item.m;
                y_op = modulus[step.j];
            end
            default:
            begin
                x_op = 64'd0;
                y_op = 64'd0;
            end
        endcase
        pp_next[0] = 64'(x_op[31:0])  * 64'(y_op[31:0]);
        pp_next[1] = 64'(x_op[63:32]) * 64'(y_op[31:0]);
        pp_next[2] = 64'(x_op[31:0])  * 64'(y_op[63:32]);
        pp_next[3] = 64'(x_op[63:32]) * 64'(y_op[63:32]);
    end

    // stage B: x*y + s + c, fits in 128 bits; update accumulator limbs, carry or m
    always_comb
    begin
        s_op = 64'd0;
        c_op = 64'd0;
        case (step.op)
            STEP_AB:
            begin
                s_op = item_a_reg.t[{1'b0, step.j}];
                c_op = (step.j == 2'd0) ? 64'd0 : item_a_reg.c;
            end
            STEP_R0:
            begin
                s_op = item_a_reg.t[0];
            end
            STEP_RJ:
            begin
                s_op = item_a_reg.t[{1'b0, step.j}];
                c_op = item_a_reg.c;
            end
            default:
            begin
                s_op = 64'd0;
            end
        endcase

        acc = {64'd0, pp_reg[0]} + {32'd0, pp_reg[1], 32'd0} + {32'd0, pp_reg[2], 32'd0}
            + {pp_reg[3], 64'd0} + {64'd0, s_op} + {64'd0, c_op};

        item_next = item_a_reg;
        case (step.op)
            STEP_AB:
            begin
                item_next.t[{1'b0, step.j}] = acc[63:0];
                item_next.c                 = acc[127:64];
                if (step.j == 2'd3)
                    item_next.t[4] = item_a_reg.t[4] + acc[127:64];
            end
            STEP_M:
            begin
                item_next.m = acc[63:0];
            end
            STEP_R0:
            begin
                item_next.c = acc[127:64];
            end
            STEP_RJ:
            begin
                item_next.t[{1'b0, jm1}] = acc[63:0];
                item_next.c              = acc[127:64];
                if (step.j == 2'd3)
                begin
                    item_next.t[3] = item_a_reg.t[4] + acc[127:64];
                    item_next.t[4] = 64'd0;
                end
            end
            default:
            begin
                item_next = item_a_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                va_reg <= in_valid;
            if (ready_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_a_reg <= in_item;
            pp_reg     <= pp_next;
        end
        if (ready_b && va_reg)
            item_b_reg <= item_next;
    end

endmodule

// ===== rtl/mfa_final.sv =====
// Final two stages: add/sub operands, then the conditional correction by p.
`include "montgomery_field_alu_256_defines.svh"
module mfa_final (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0][63:0]    modulus,
    input  logic                in_valid,
    output logic                in_ready,
    input  mfa_pkg::mfa_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [255:0]        result
);
    import mfa_pkg::*;

    logic         va_reg;
    logic [1:0]   kind_a_reg;
    logic [255:0] x_reg;
    logic         flag_reg;
    logic         vb_reg;
    logic [1:0]   kind_b_reg;
    logic [255:0] r_reg;

    logic         ready_b;
    logic [255:0] x_next;
    logic         flag_next;
    logic [256:0] wide;
    logic [256:0] diff;
    logic [255:0] r_next;

    assign ready_b   = !vb_reg || out_ready;
    assign in_ready  = !va_reg || ready_b;
    assign out_valid = vb_reg;
    assign result    = r_reg;

    always_comb
    begin
        wide      = 257'd0;
        x_next    = 256'd0;
        flag_next = 1'b0;
        case (in_item.kind)
            KIND_MUL:
            begin
                x_next = in_item.t[3:0];
            end
            KIND_ADD:
            begin
                wide      = {1'b0, in_item.a} + {1'b0, in_item.b};
                x_next    = wide[255:0];
                flag_next = wide[256];
            end
            KIND_SUB:
            begin
                wide      = {1'b0, in_item.a} - {1'b0, in_item.b};
                x_next    = wide[255:0];
                flag_next = wide[256];
            end
            default:
            begin
                x_next = 256'd0;
            end
        endcase
    end

    always_comb
    begin
        diff   = {1'b0, x_reg} - {1'b0, modulus};
        case (kind_a_reg)
            KIND_MUL: r_next = diff[256] ? x_reg : diff[255:0];
            KIND_ADD: r_next = (flag_reg || !diff[256]) ? diff[255:0] : x_reg;
            KIND_SUB: r_next = flag_reg ? (x_reg + modulus) : x_reg;
            default:  r_next = 256'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                va_reg <= in_valid;
            if (ready_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_a_reg <= in_item.kind;
            x_reg      <= x_next;
            flag_reg   <= flag_next;
        end
        if (ready_b && va_reg)
        begin
            kind_b_reg <= kind_a_reg;
            r_reg      <= r_next;
        end
    end

    `MFA_ASSERT_NEXT(a_out_hold, vb_reg && !out_ready, vb_reg && $stable(r_reg), "result changed while stalled")
    `MFA_ASSERT_NEXT(a_mid_hold, va_reg && !ready_b, va_reg && $stable(x_reg), "mid stage lost item")
    `MFA_ASSERT_NOW(a_none_zero, vb_reg && kind_b_reg == KIND_NONE, r_reg == 256'd0, "unused kind not zero")

endmodule

// ===== rtl/montgomery_field_alu_256.sv =====
// Top level of the 256-bit Montgomery field ALU: APB registers, cell chain, final stages.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | tuser kind, tdata a and b limbs
//  m_*     | out | m_tvalid/m_tready  | tdata r limbs
//  apb     | in  | psel/penable       | modulus limbs, mont_factor
//
// One request per cycle sustained unless the output stalls; 36 CIOS cells of
// two stages each (four 32x32 partial products, then the 128-bit sum with the
// accumulator limb and carry), nine cells per round, four rounds, plus two
// stages for add/sub and the final correction by p. Each stage holds its item
// only while the next one is full and stalled, so bubbles collapse and the
// input keeps being taken while a result waits, until all stages are full.
// Reset clears valid flags and the configuration registers, not the datapath.
module montgomery_field_alu_256 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [511:0]  s_tdata,  // a_limb0..a_limb3, b_limb0..b_limb3
    input  logic [1:0]    s_tuser,  // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [255:0]  m_tdata   // r_limb0..r_limb3
);
    import mfa_pkg::*;

    localparam logic [2:0] REG_P0 = 3'd0;
    localparam logic [2:0] REG_P1 = 3'd1;
    localparam logic [2:0] REG_P2 = 3'd2;
    localparam logic [2:0] REG_P3 = 3'd3;
    localparam logic [2:0] REG_MF = 3'd4;

    logic [3:0][63:0] modulus_reg;
    logic [63:0]      mf_reg;
    logic [2:0]       reg_idx;
    logic             wr_en;

    logic      valid [0:N_CELLS];
    logic      ready [0:N_CELLS];
    mfa_item_t item  [0:N_CELLS];

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    // register file, to be written only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= '0;
            mf_reg      <= 64'd0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_P0:  modulus_reg[0] <= pwdata;
                REG_P1:  modulus_reg[1] <= pwdata;
                REG_P2:  modulus_reg[2] <= pwdata;
                REG_P3:  modulus_reg[3] <= pwdata;
                REG_MF:  mf_reg         <= pwdata;
                default: mf_reg         <= mf_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_P0:  prdata = modulus_reg[0];
            REG_P1:  prdata = modulus_reg[1];
            REG_P2:  prdata = modulus_reg[2];
            REG_P3:  prdata = modulus_reg[3];
            REG_MF:  prdata = mf_reg;
            default: prdata = 64'd0;
        endcase
    end

    // fresh item: accumulator, carry and m start at zero
    always_comb
    begin
        item[0]      = '0;
        item[0].kind = s_tuser;
        item[0].a    = s_tdata[255:0];
        item[0].b    = s_tdata[511:256];
    end
    assign valid[0] = s_tvalid;
    assign s_tready = ready[0];

    // cell k runs step k mod 9 of round k / 9
    for (genvar k = 0; k < N_CELLS; k++)
    begin : g_cell
        localparam int RND = k / STEPS_RND;
        localparam int SUB = k % STEPS_RND;
        mfa_step_t step;
        always_comb
        begin
            step.i = 2'(RND);
            if (SUB < LIMBS)
            begin
                step.op = STEP_AB;
                step.j  = 2'(SUB);
            end
            else if (SUB == LIMBS)
            begin
                step.op = STEP_M;
                step.j  = 2'd0;
            end
            else if (SUB == LIMBS + 1)
            begin
                step.op = STEP_R0;
                step.j  = 2'd0;
            end
            else
            begin
                step.op = STEP_RJ;
                step.j  = 2'(SUB - LIMBS - 1);
            end
        end

        mfa_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (step),
            .modulus     (modulus_reg),
            .mont_factor (mf_reg),
            .in_valid    (valid[k]),
            .in_ready    (ready[k]),
            .in_item     (item[k]),
            .out_valid   (valid[k+1]),
            .out_ready   (ready[k+1]),
            .out_item    (item[k+1])
        );
    end

    mfa_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .modulus   (modulus_reg),
        .in_valid  (valid[N_CELLS]),
        .in_ready  (ready[N_CELLS]),
        .in_item   (item[N_CELLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (m_tdata)
    );

endmodule

// ===== tb/montgomery_field_alu_256_tb.sv =====
// Testbench for the 256-bit Montgomery field ALU: random and directed requests against a predictor.
module montgomery_field_alu_256_tb;
    import mfa_pkg::*;

    // Register byte addresses (64-bit registers, so 8 bytes apart).
    localparam logic [5:0] ADDR_P0   = 6'd0;
    localparam logic [5:0] ADDR_P1   = 6'd8;
    localparam logic [5:0] ADDR_P2   = 6'd16;
    localparam logic [5:0] ADDR_P3   = 6'd24;
    localparam logic [5:0] ADDR_MINV = 6'd32;
    localparam int LATENCY     = 74;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [3:0][63:0] wide_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [511:0] s_tdata;   // a_limb0..a_limb3, b_limb0..b_limb3
    logic [1:0]   s_tuser;   // kind
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;   // r_limb0..r_limb3

    // Field parameters as the predictor sees them.
    wide_t       cur_p;
    logic [63:0] cur_minv;

    // Four-limb add/sub with carry/borrow out.
    function automatic logic [256:0] wadd(wide_t x, wide_t y);
        return {1'b0, x} + {1'b0, y};
    endfunction

    function automatic logic [256:0] wsub(wide_t x, wide_t y);
        return {1'b0, x} - {1'b0, y};
    endfunction

    // CIOS Montgomery product, top accumulator limb wraps at 64 bits.
    function automatic wide_t cios_product(wide_t a, wide_t b, wide_t p, logic [63:0] minv);
        logic [63:0]  t [5];
        logic [127:0] acc;
        logic [63:0]  c;
        logic [63:0]  m;
        logic [256:0] d;
        wide_t        tv;
        for (int k = 0; k < 5; k++) t[k] = '0;
        for (int i = 0; i < 4; i++)
        begin
            c = '0;
            for (int j = 0; j < 4; j++)
            begin
                acc = 128'(a[i]) * 128'(b[j]) + 128'(t[j]) + 128'(c);
                t[j] = acc[63:0];
                c = acc[127:64];
            end
            t[4] = t[4] + c;
            m = t[0] * minv;
            acc = 128'(m) * 128'(p[0]) + 128'(t[0]);
            c = acc[127:64];
            for (int j = 1; j < 4; j++)
            begin
                acc = 128'(m) * 128'(p[j]) + 128'(t[j]) + 128'(c);
                t[j-1] = acc[63:0];
                c = acc[127:64];
            end
            t[3] = t[4] + c;
            t[4] = '0;
        end
        for (int k = 0; k < 4; k++) tv[k] = t[k];
        d = wsub(tv, p);
        return d[256] ? tv : d[255:0];
    endfunction

    function automatic wide_t field_result(kind_t k, wide_t a, wide_t b);
        logic [256:0] s;
        logic [256:0] d;
        case (k)
            KIND_MUL: return cios_product(a, b, cur_p, cur_minv);
            KIND_ADD:
            begin
                s = wadd(a, b);
                d = wsub(s[255:0], cur_p);
                return (s[256] || !d[256]) ? d[255:0] : s[255:0];
            end
            KIND_SUB:
            begin
                d = wsub(a, b);
                if (d[256])
                begin
                    s = wadd(d[255:0], cur_p);
                    return s[255:0];
                end
                return d[255:0];
            end
            default: return '0;
        endcase
    endfunction

    class result_board;
        wide_t pending[$];
        int    errors;
        int    shown;

        function void note_request(kind_t k, wide_t a, wide_t b);
            pending.push_back(field_result(k, a, b));
        endfunction

        function void check_result(wide_t got);
            wide_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected result %h", got);
                end
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 4; k++)
                if (got[k] !== want[k])
                begin
                    errors++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("r_limb%0d mismatch: expected %h actual %h", k, want[k], got[k]);
                    end
                end
        endfunction
    endclass

    result_board board;
    int          cycles = 0;
    bit          timed_out = 1'b0;

    montgomery_field_alu_256 dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("montgomery_field_alu_256 verification failed");
            $finish;
        end
    end

    // Results are checked as they are accepted.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);

    // Receiver: random stall before each result, with calm stretches.
    initial
    begin
        int w;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (((cycles / 2000) % 3) == 1) w = 0;
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic reg_write(logic [5:0] addr, logic [63:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Modulus and factor are loaded only with nothing in flight.
    task automatic load_field(wide_t p, logic [63:0] minv);
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        reg_write(ADDR_P0, p[0]);
        reg_write(ADDR_P1, p[1]);
        reg_write(ADDR_P2, p[2]);
        reg_write(ADDR_P3, p[3]);
        reg_write(ADDR_MINV, minv);
        cur_p = p;
        cur_minv = minv;
    endtask

    // -p^-1 mod 2^64 by Newton iteration.
    function automatic logic [63:0] neg_inv(logic [63:0] p0);
        logic [63:0] x;
        x = p0;
        for (int k = 0; k < 6; k++) x = x * (64'd2 - p0 * x);
        return -x;
    endfunction

    // tvalid stays high across back-to-back requests; dropped only for a gap.
    task automatic send(kind_t k, wide_t a, wide_t b, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 12) : 0;
        if (w > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        s_tvalid <= 1'b1; s_tuser <= k; s_tdata <= {b, a};
        do @(posedge clk); while (!s_tready);
        board.note_request(k, a, b);
    endtask

    function automatic wide_t rand_wide();
        wide_t v;
        for (int k = 0; k < 4; k++) v[k] = {$urandom(), $urandom()};
        return v;
    endfunction

    // Random value below p when p[3] is nonzero: mostly reduced, ends of the range mixed in.
    function automatic wide_t rand_below(wide_t p);
        wide_t v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = wide_t'(256'(p) - 256'd1);
            2: v = wide_t'($urandom_range(0, 5));
            default:
            begin
                v = rand_wide();
                v[3] = 64'({1'b0, v[3]} % ({1'b0, p[3]} + 65'd1));
                if (256'(v) >= 256'(p)) v = wide_t'(256'(v) - 256'(p));
            end
        endcase
        return v;
    endfunction

    function automatic wide_t rand_modulus(bit biggest);
        wide_t p;
        p = rand_wide();
        p[0][0] = 1'b1;
        p[3][63] = 1'b0;
        if (biggest) p[3][62] = 1'b1;
        return p;
    endfunction

    task automatic random_phase(int count);
        kind_t k;
        wide_t a;
        wide_t b;
        bit    calm;
        for (int n = 0; n < count; n++)
        begin
            calm = (n % 100) < 25;
            case ($urandom_range(0, 19))
                0: k = KIND_NONE;
                1, 2, 3, 4, 5, 6, 7, 8: k = KIND_MUL;
                9, 10, 11, 12, 13: k = KIND_ADD;
                default: k = KIND_SUB;
            endcase
            // A few unreduced operands as noise.
            if ($urandom_range(0, 15) == 0)
            begin
                a = rand_wide();
                b = rand_wide();
            end
            else
            begin
                a = rand_below(cur_p);
                b = rand_below(cur_p);
            end
            send(k, a, b, !calm);
        end
    endtask

    initial
    begin
        wide_t p;
        wide_t ones;
        board = new();
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = KIND_MUL;
        cur_p = '0;
        cur_minv = '0;
        ones = '1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: modulus and factor zero.
        send(KIND_ADD, ones, ones, 1'b0);
        send(KIND_SUB, '0, ones, 1'b0);
        send(KIND_MUL, ones, ones, 1'b0);

        // Odd modulus 2^254-9, made from 2^255-19 shifted right, just below 2^254.
        p = wide_t'({1'b0, {236{1'b1}}, 19'h7ffed} >> 1);
        p[0][0] = 1'b1;
        load_field(p, neg_inv(p[0]));
        send(KIND_MUL, '0, '0, 1'b0);
        send(KIND_MUL, wide_t'(256'(p) - 1), wide_t'(256'(p) - 1), 1'b0);
        send(KIND_MUL, wide_t'(256'd1), wide_t'(256'd1), 1'b0);
        send(KIND_MUL, ones, ones, 1'b0);                // unreduced, wraps past 256 bits
        send(KIND_ADD, wide_t'(256'(p) - 1), wide_t'(256'd1), 1'b0);
        send(KIND_ADD, wide_t'(256'(p) - 1), wide_t'(256'(p) - 1), 1'b0);
        send(KIND_ADD, ones, ones, 1'b0);                // carry past 256 bits
        send(KIND_ADD, '0, '0, 1'b0);
        send(KIND_SUB, '0, wide_t'(256'd1), 1'b0);
        send(KIND_SUB, '0, ones, 1'b0);                  // borrow, add-back gives p + 1
        send(KIND_SUB, wide_t'(256'(p) - 1), wide_t'(256'(p) - 1), 1'b0);
        send(KIND_SUB, ones, '0, 1'b0);
        send(KIND_NONE, ones, ones, 1'b0);
        send(KIND_NONE, '0, '0, 1'b0);

        // Smallest odd modulus and a tiny one.
        load_field(wide_t'(256'd1), neg_inv(64'd1));
        random_phase(30);
        load_field(wide_t'(256'd13), neg_inv(64'd13));
        random_phase(60);

        // Wrong factor: datapath runs unchanged.
        load_field(rand_modulus(1'b1), {$urandom(), $urandom()});
        random_phase(60);

        // Widest moduli with bit 63 set in the top limb (overflow region).
        p = rand_wide();
        p[0][0] = 1'b1;
        p[3] = '1;
        load_field(p, neg_inv(p[0]));
        random_phase(60);

        for (int ph = 0; ph < 4; ph++)
        begin
            p = rand_modulus(ph[0]);
            load_field(p, neg_inv(p[0]));
            random_phase(200);
        end

        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (board.errors == 0)
            $display("montgomery_field_alu_256 verification clean");
        else
            $display("montgomery_field_alu_256 verification failed");
        $finish;
    end
endmodule
